/* rtl/quadratic_root_solver_top_assert.svh */
// Assertion helpers used by the solver core.
// Both sample on aclk and stay off while aresetn is low.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define QRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qrs: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qrs: next-cycle check failed");

`endif

/* rtl/qrs_pkg.sv */
`default_nettype none
package qrs_pkg;

    localparam int QRS_COEF_WIDTH = 16;
    localparam int QRS_FRAC_BITS  = 12;
    localparam int QRS_ROOT_WIDTH = 32;

    typedef enum logic [1:0] {
        RS_NONE  = 2'd0,
        RS_ONE   = 2'd1,
        RS_TWO   = 2'd2,
        RS_AZERO = 2'd3
    } qrs_status_t;

    typedef struct packed {
        logic start;
        logic take;
    } qrs_ctl_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        qrs_status_t status;
    } qrs_stat_t;

endpackage
`default_nettype wire

/* rtl/quadratic_root_solver_top.sv */
`default_nettype none
// Fixed-point quadratic solver: takes signed a, b, c and returns the status and up to
// two real roots of a*x^2 + b*x + c, each truncated toward zero with FRAC_BITS fraction
// bits and saturated to 32 signed bits. The discriminant is exact. One equation is in
// flight at a time; s_tready stays low while it is worked on. A zero a or a negative
// discriminant ends the work early. The work is paced by the single compare-subtract
// unit, which runs the square root two radicand bits per cycle and each division one
// quotient bit per cycle. A finished word waits in the output register, so the next
// equation can be accepted while m_tready is low.
module quadratic_root_solver_top import qrs_pkg::*; #(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // s_tdata: coef_a, coef_b, coef_c (COEF_WIDTH bits each), zero pad to bytes
    input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // m_tdata: root_first [31:0], root_second [63:32]
    output logic [2*QRS_ROOT_WIDTH-1:0]                m_tdata,
    // m_tuser: root_status [1:0]
    output logic [1:0]                                 m_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready
);

    localparam int CW = COEF_WIDTH;

    qrs_ctl_t                  ctl;
    qrs_stat_t                 stat;
    logic [QRS_ROOT_WIDTH-1:0] core_r1, core_r2;

    logic                      m_valid_reg, m_valid_next;
    logic [QRS_ROOT_WIDTH-1:0] r1_reg,      r1_next;
    logic [QRS_ROOT_WIDTH-1:0] r2_reg,      r2_next;
    qrs_status_t               status_reg,  status_next;

    assign s_tready  = ~stat.busy;
    assign ctl.start = s_tvalid & s_tready;
    // move the result into the output register when it is empty or draining
    assign ctl.take  = stat.done & (~m_valid_reg | m_tready);

    qrs_core #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .coef_a      ($signed(s_tdata[CW-1:0])),
        .coef_b      ($signed(s_tdata[2*CW-1:CW])),
        .coef_c      ($signed(s_tdata[3*CW-1:2*CW])),
        .stat        (stat),
        .root_first  (core_r1),
        .root_second (core_r2)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        r1_next      = r1_reg;
        r2_next      = r2_reg;
        status_next  = status_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.take) begin
            m_valid_next = 1'b1;
            r1_next      = core_r1;
            r2_next      = core_r2;
            status_next  = stat.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        r1_reg     <= r1_next;
        r2_reg     <= r2_next;
        status_reg <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {r2_reg, r1_reg};
    assign m_tuser  = status_reg;

endmodule
`default_nettype wire

/* rtl/qrs_cmpsub.sv */
`default_nettype none
module qrs_cmpsub import qrs_pkg::*; #(
    parameter int WIDTH = QRS_COEF_WIDTH + QRS_FRAC_BITS + 4
) (
    input  wire logic [WIDTH-1:0] op_x,
    input  wire logic [WIDTH-1:0] op_y,
    output logic      [WIDTH-1:0] diff,
    output logic                  ge
);

    logic [WIDTH:0] full;

    assign full = {1'b0, op_x} - {1'b0, op_y};
    // no borrow out means op_x >= op_y
    assign ge   = ~full[WIDTH];
    assign diff = full[WIDTH-1:0];

endmodule
`default_nettype wire

/* rtl/qrs_core.sv */
`default_nettype none
`include "quadratic_root_solver_top_assert.svh"
module qrs_core import qrs_pkg::*; #(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire qrs_ctl_t                      ctl,
    input  wire logic signed [COEF_WIDTH-1:0]  coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]  coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]  coef_c,
    output qrs_stat_t                          stat,
    output logic [QRS_ROOT_WIDTH-1:0]          root_first,
    output logic [QRS_ROOT_WIDTH-1:0]          root_second
);

    localparam int CW    = COEF_WIDTH;
    localparam int PW    = 2 * CW;
    localparam int DW    = 2 * CW + 1;
    localparam int RW    = DW + 2 * FRAC_BITS + 1;
    localparam int SW    = RW / 2;
    localparam int NW    = CW + FRAC_BITS + 2;
    localparam int UW    = SW + 3;
    localparam int XW    = (NW > QRS_ROOT_WIDTH ? NW : QRS_ROOT_WIDTH) + 1;
    localparam int CNT_W = $clog2(NW);

    localparam logic [XW-1:0] POS_LIM = XW'((64'd1 << (QRS_ROOT_WIDTH - 1)) - 64'd1);
    localparam logic [XW-1:0] NEG_LIM = XW'(64'd1 << (QRS_ROOT_WIDTH - 1));

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_B,
        S_MUL_AC,
        S_DISC,
        S_SQRT,
        S_NUM,
        S_DIV,
        S_FIX,
        S_DONE
    } state_t;

    state_t                    state_reg,  state_next;
    qrs_status_t               status_reg, status_next;
    logic [CNT_W-1:0]          cnt_reg,    cnt_next;
    logic                      second_reg, second_next;
    logic signed [CW-1:0]      a_reg,      a_next;
    logic signed [CW-1:0]      b_reg,      b_next;
    logic signed [CW-1:0]      c_reg,      c_next;
    logic [PW-1:0]             b2_reg,     b2_next;
    logic [PW-1:0]             ac_reg,     ac_next;
    logic [RW-1:0]             rad_reg,    rad_next;
    logic [SW-1:0]             root_reg,   root_next;
    logic [SW:0]               rem_reg,    rem_next;
    logic [NW-1:0]             num_reg,    num_next;
    logic [CW:0]               drem_reg,   drem_next;
    logic                      neg_reg,    neg_next;
    logic [QRS_ROOT_WIDTH-1:0] r1_reg,     r1_next;
    logic [QRS_ROOT_WIDTH-1:0] r2_reg,     r2_next;

    // operand magnitudes
    logic [CW-1:0] a_mag, b_mag, c_mag;
    logic [CW:0]   den;
    assign a_mag = a_reg[CW-1] ? CW'(-a_reg) : CW'(a_reg);
    assign b_mag = b_reg[CW-1] ? CW'(-b_reg) : CW'(b_reg);
    assign c_mag = c_reg[CW-1] ? CW'(-c_reg) : CW'(c_reg);
    assign den   = {a_mag, 1'b0};

    // one multiplier, b*b first then a*c
    logic [CW-1:0] mul_x, mul_y;
    logic [PW-1:0] prod;
    assign mul_x = (state_reg == S_MUL_B) ? b_mag : a_mag;
    assign mul_y = (state_reg == S_MUL_B) ? b_mag : c_mag;
    assign prod  = mul_x * mul_y;

    // discriminant
    logic [PW+1:0] four_ac, b2_x, d_sum, d_dif;
    logic [DW-1:0] d_val;
    logic          ac_neg, d_neg, d_zero;
    assign four_ac = {ac_reg, 2'b00};
    assign b2_x    = (PW + 2)'(b2_reg);
    assign d_sum   = b2_x + four_ac;
    assign d_dif   = b2_x - four_ac;
    assign ac_neg  = (a_reg[CW-1] != c_reg[CW-1]) && (c_reg != '0);
    assign d_neg   = !ac_neg && (four_ac > b2_x);
    assign d_val   = ac_neg ? d_sum[DW-1:0] : d_dif[DW-1:0];
    assign d_zero  = (d_val == '0);

    // numerator -b*2^F +/- s
    logic signed [NW:0] b_ext, nb, s_ext, num_s;
    logic [NW-1:0]      num_mag;
    assign b_ext   = (NW + 1)'(b_reg);
    assign nb      = -(b_ext <<< FRAC_BITS);
    assign s_ext   = $signed((NW + 1)'(root_reg));
    assign num_s   = second_reg ? (nb - s_ext) : (nb + s_ext);
    assign num_mag = num_s[NW] ? NW'(-num_s) : NW'(num_s);

    // shared compare-subtract unit
    logic [SW+2:0] rem_sh;
    logic [SW+1:0] trial;
    logic [CW+1:0] drem_sh;
    logic [UW-1:0] unit_x, unit_y, unit_diff;
    logic          unit_ge;
    assign rem_sh  = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial   = {root_reg, 2'b01};
    assign drem_sh = {drem_reg, num_reg[NW-1]};

    always_comb begin
        if (state_reg == S_SQRT) begin
            unit_x = UW'(rem_sh);
            unit_y = UW'(trial);
        end else begin
            unit_x = UW'(drem_sh);
            unit_y = UW'(den);
        end
    end

    qrs_cmpsub #(
        .WIDTH (UW)
    ) u_cmpsub (
        .op_x (unit_x),
        .op_y (unit_y),
        .diff (unit_diff),
        .ge   (unit_ge)
    );

    // saturate and sign the quotient
    logic [XW-1:0]             q_x, lim, clamp;
    logic [QRS_ROOT_WIDTH-1:0] sat_root;
    assign q_x      = XW'(num_reg);
    assign lim      = neg_reg ? NEG_LIM : POS_LIM;
    assign clamp    = (q_x > lim) ? lim : q_x;
    assign sat_root = neg_reg ? QRS_ROOT_WIDTH'(-clamp) : QRS_ROOT_WIDTH'(clamp);

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cnt_next    = cnt_reg;
        second_next = second_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        b2_next     = b2_reg;
        ac_next     = ac_reg;
        rad_next    = rad_reg;
        root_next   = root_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        drem_next   = drem_reg;
        neg_next    = neg_reg;
        r1_next     = r1_reg;
        r2_next     = r2_reg;
        case (state_reg)
            S_IDLE: begin
                if (ctl.start) begin
                    a_next      = coef_a;
                    b_next      = coef_b;
                    c_next      = coef_c;
                    r1_next     = '0;
                    r2_next     = '0;
                    second_next = 1'b0;
                    if (coef_a == '0) begin
                        status_next = RS_AZERO;
                        state_next  = S_DONE;
                    end else begin
                        state_next  = S_MUL_B;
                    end
                end
            end
            S_MUL_B: begin
                b2_next    = prod;
                state_next = S_MUL_AC;
            end
            S_MUL_AC: begin
                ac_next    = prod;
                state_next = S_DISC;
            end
            S_DISC: begin
                if (d_neg) begin
                    status_next = RS_NONE;
                    state_next  = S_DONE;
                end else begin
                    status_next = d_zero ? RS_ONE : RS_TWO;
                    rad_next    = RW'(d_val) << (2 * FRAC_BITS);
                    root_next   = '0;
                    rem_next    = '0;
                    cnt_next    = CNT_W'(SW - 1);
                    state_next  = S_SQRT;
                end
            end
            S_SQRT: begin
                // two radicand bits per step
                rem_next  = unit_ge ? unit_diff[SW:0] : rem_sh[SW:0];
                root_next = {root_reg[SW-2:0], unit_ge};
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_NUM;
                end
            end
            S_NUM: begin
                num_next   = num_mag;
                neg_next   = num_s[NW] ^ a_reg[CW-1];
                drem_next  = '0;
                cnt_next   = CNT_W'(NW - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                // quotient bits shift in behind the dividend
                drem_next = unit_ge ? unit_diff[CW:0] : drem_sh[CW:0];
                num_next  = {num_reg[NW-2:0], unit_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                if (second_reg) begin
                    r2_next    = sat_root;
                    state_next = S_DONE;
                end else begin
                    r1_next = sat_root;
                    if (status_reg == RS_TWO) begin
                        second_next = 1'b1;
                        state_next  = S_NUM;
                    end else begin
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (ctl.take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= RS_NONE;
            cnt_reg    <= '0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            cnt_reg    <= cnt_next;
            second_reg <= second_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        b2_reg   <= b2_next;
        ac_reg   <= ac_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        drem_reg <= drem_next;
        neg_reg  <= neg_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
    end

    assign stat.busy   = (state_reg != S_IDLE);
    assign stat.done   = (state_reg == S_DONE);
    assign stat.status = status_reg;
    assign root_first  = r1_reg;
    assign root_second = r2_reg;

    `QRS_ASSERT_NOW(a_start_idle, ctl.start, state_reg == S_IDLE)
    `QRS_ASSERT_NOW(a_azero_coef, state_reg == S_DONE && status_reg == RS_AZERO, a_reg == '0)
    `QRS_ASSERT_NOW(a_second_zero, state_reg == S_DONE && status_reg != RS_TWO, r2_reg == '0)
    `QRS_ASSERT_NEXT(a_sqrt_end, state_reg == S_SQRT && cnt_reg == '0, state_reg == S_NUM)
    `QRS_ASSERT_NEXT(a_div_end, state_reg == S_DIV && cnt_reg == '0, state_reg == S_FIX)

endmodule
`default_nettype wire

/* tb/sv/qrs_root_checker.sv */
`timescale 1ns / 1ps
module qrs_root_checker import qrs_pkg::*; #(
    parameter int SW = ((3*QRS_COEF_WIDTH+7)/8)*8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // s_tdata: coef_a, coef_b, coef_c, zero pad
    input  wire logic [SW-1:0]               s_tdata,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    // m_tdata: root_first, root_second
    input  wire logic [2*QRS_ROOT_WIDTH-1:0] m_tdata,
    // m_tuser: root_status
    input  wire logic [1:0]                  m_tuser,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    output int                               due_count,
    output int                               mismatch_count,
    output int                               n_none,
    output int                               n_one,
    output int                               n_two,
    output int                               n_azero
);

    localparam int CW = QRS_COEF_WIDTH;
    localparam int FB = QRS_FRAC_BITS;
    localparam int RW = QRS_ROOT_WIDTH;

    typedef struct packed {
        qrs_status_t   status;
        logic [RW-1:0] first;
        logic [RW-1:0] second;
    } root_set_t;

    root_set_t roots_due[$];
    root_set_t got;
    root_set_t want;

    function automatic logic [RW-1:0] clamp_root(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (RW - 1)) - 1;
        lo = -(longint'(1) <<< (RW - 1));
        if (v > hi) v = hi;
        else if (v < lo) v = lo;
        return v[RW-1:0];
    endfunction

    function automatic root_set_t solve_roots(input logic [SW-1:0] coefs);
        longint       a;
        longint       b;
        longint       c;
        longint       disc;
        longint       num;
        longint       den;
        logic [127:0] rad;
        logic [127:0] rem;
        logic [127:0] trial;
        logic [127:0] sq;
        root_set_t    r;
        a = $signed(coefs[0 +: CW]);
        b = $signed(coefs[CW +: CW]);
        c = $signed(coefs[2*CW +: CW]);
        r = '0;
        r.status = RS_NONE;
        if (a == 0) begin
            r.status = RS_AZERO;
            return r;
        end
        disc = b * b - 4 * a * c;
        if (disc < 0) return r;
        num = -b * (longint'(1) <<< FB);
        den = 2 * a;
        if (disc == 0) begin
            r.status = RS_ONE;
            r.first = clamp_root(num / den);
            return r;
        end
        // floor square root of the scaled discriminant, two radicand bits per pass
        rad = 128'(disc) << (2 * FB);
        rem = '0;
        sq = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
            trial = (sq << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                sq = (sq << 1) | 128'd1;
            end else begin
                sq = sq << 1;
            end
        end
        r.status = RS_TWO;
        r.first = clamp_root((num + longint'(sq)) / den);
        r.second = clamp_root((num - longint'(sq)) / den);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            roots_due.delete();
            mismatch_count = 0;
            due_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = qrs_status_t'(m_tuser);
                got.first = m_tdata[RW-1:0];
                got.second = m_tdata[2*RW-1:RW];
                if (roots_due.size() == 0) begin
                    $error("result word with no equation pending");
                    mismatch_count++;
                end else begin
                    want = roots_due.pop_front();
                    case (want.status)
                        RS_NONE:  n_none++;
                        RS_ONE:   n_one++;
                        RS_TWO:   n_two++;
                        default:  n_azero++;
                    endcase
                    if (got.status !== want.status) begin
                        $error("root_status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatch_count++;
                    end
                    if (got.first !== want.first) begin
                        $error("root_first: expected %0d, actual %0d",
                               $signed(want.first), $signed(got.first));
                        mismatch_count++;
                    end
                    if (got.second !== want.second) begin
                        $error("root_second: expected %0d, actual %0d",
                               $signed(want.second), $signed(got.second));
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                roots_due.push_back(solve_roots(s_tdata));
            due_count <= roots_due.size();
        end
    end

endmodule

/* tb/sv/tb_quadratic_root_solver_top.sv */
`timescale 1ns / 1ps
module tb_quadratic_root_solver_top;
    import qrs_pkg::*;

    localparam int CW           = QRS_COEF_WIDTH;
    localparam int SW           = ((3*CW+7)/8)*8;
    localparam int RW           = QRS_ROOT_WIDTH;
    localparam int RANDOM_EQNS  = 830;
    localparam int HOLD_AT      = 20000;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 150;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic [SW-1:0]   s_tdata  = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [2*RW-1:0] m_tdata;
    logic [1:0]      m_tuser;
    logic            m_tvalid;
    logic            m_tready = 1'b0;

    int due_count;
    int mismatch_count;
    int n_none;
    int n_one;
    int n_two;
    int n_azero;
    int sent_count  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    always #6 aclk = ~aclk;

    quadratic_root_solver_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    qrs_root_checker u_root_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .due_count      (due_count),
        .mismatch_count (mismatch_count),
        .n_none         (n_none),
        .n_one          (n_one),
        .n_two          (n_two),
        .n_azero        (n_azero)
    );

    // Offer one equation and hold it until accepted; drop valid between bursts.
    task automatic send_eqn(input int a, input int b, input int c);
        logic [CW-1:0] fa;
        logic [CW-1:0] fb;
        logic [CW-1:0] fc;
        int            gap;
        fa = a[CW-1:0];
        fb = b[CW-1:0];
        fc = c[CW-1:0];
        s_tdata <= SW'({fc, fb, fa});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    initial begin : stimulus
        int kind;
        int a;
        int b;
        int c;
        int k;
        int r1;
        int r2;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // zero a
        send_eqn(0, 0, 0);
        send_eqn(0, -32768, 32767);
        // negative discriminant
        send_eqn(1, 0, 1);
        send_eqn(32767, 32767, 32767);
        send_eqn(-32768, 0, -32768);
        // zero discriminant
        send_eqn(1, 2, 1);
        send_eqn(-3, 6, -3);
        send_eqn(16384, -32768, 16384);
        send_eqn(1, 0, 0);
        send_eqn(-32768, 0, 0);
        // two roots, including coefficient extremes
        send_eqn(1, -3, 2);
        send_eqn(-1, 0, 1);
        send_eqn(-32768, -32768, 32767);
        send_eqn(-32768, 32767, 32767);
        send_eqn(32767, -32768, -32768);
        send_eqn(1, 32767, -32768);
        send_eqn(1, -32768, 0);
        send_eqn(-1, -32768, 32767);
        send_eqn(1, 1, 0);
        send_eqn(32767, 0, -32768);

        for (int n = 0; n < RANDOM_EQNS; n++) begin
            kind = $urandom_range(0, 9);
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535)) - 32768;
            c = int'($urandom_range(0, 65535)) - 32768;
            k = $urandom_range(1, 16);
            if ($urandom_range(0, 1) == 1) k = -k;
            r1 = int'($urandom_range(0, 80)) - 40;
            r2 = int'($urandom_range(0, 80)) - 40;
            case (kind)
                4: a = 0;
                5: begin
                    a = int'($urandom_range(0, 16)) - 8;
                    b = int'($urandom_range(0, 16)) - 8;
                    c = int'($urandom_range(0, 16)) - 8;
                end
                6, 7: begin
                    // integer roots r1 and r2
                    a = k;
                    b = -k * (r1 + r2);
                    c = k * r1 * r2;
                end
                8: begin
                    // double root at r1
                    a = k;
                    b = -2 * k * r1;
                    c = k * r1 * r1;
                end
                9: a = int'($urandom_range(0, 8)) - 4;
                default: ;
            endcase
            send_eqn(a, b, c);
        end
        if (s_tvalid) s_tvalid <= 1'b0;

        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Solved %0d equations: %0d with two roots, %0d with one, %0d with none, %0d with zero a.",
                 sent_count, n_two, n_one, n_none, n_azero);
        $display("Input bursts, output stall patterns and a %0d-cycle output hold-off were applied.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : receiver
        int mode;
        int left;
        int ticks;
        mode = 0;
        left = 0;
        ticks = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            ticks++;
            // hold off long enough for the solver to fill and stall its input
            if (ticks == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 200);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 4) == 0);
                default: m_tready <= (left < 4);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
